### hdl/irot_pkg.sv
// Shared types and constants for the quarter-turn image rotator.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package irot_pkg;

	localparam int PIX_W       = 8;
	localparam int COORD_W     = 8;
	localparam int SIZE_W      = 9;
	localparam int ADDR_W      = 16;
	localparam int CFG_IDX_W   = 8;
	localparam int MAX_ROWS    = 256;
	localparam int MAX_COLS    = 256;
	localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int OUT_W       = PIX_W + 2 * COORD_W;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_CODE = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLOCKWISE  = 8'd3;

	// Item opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Angle codes
	localparam logic [1:0] ANG_0   = 2'd0;
	localparam logic [1:0] ANG_90  = 2'd1;
	localparam logic [1:0] ANG_180 = 2'd2;
	localparam logic [1:0] ANG_270 = 2'd3;

	// Net clockwise quarter turns
	localparam logic [1:0] TURN_0 = 2'd0;
	localparam logic [1:0] TURN_1 = 2'd1;
	localparam logic [1:0] TURN_2 = 2'd2;
	localparam logic [1:0] TURN_3 = 2'd3;

	typedef struct packed {
		logic wr;      // store the accepted pixel
		logic rd;      // register the read address and advance the read position
		logic mem_rd;  // read the frame store
		logic load;    // move the fetched pixel into the output register
	} irot_cmd_t;

	typedef struct packed {
		logic full;      // whole frame written
		logic out_free;  // output register empty or being emptied this cycle
	} irot_status_t;

endpackage

### hdl/irot_ctrl.sv
// Controller of the quarter-turn image rotator: item acceptance and read sequencing.
// Depends on irot_pkg for the command and status structs.
`timescale 1ns / 1ps

module irot_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  opcode,
	output logic                  s_tready,
	input  irot_pkg::irot_status_t status,
	output irot_pkg::irot_cmd_t   cmd
);
	import irot_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd        = '0;
		cmd.wr     = accept && (opcode == OP_WRITE);
		cmd.rd     = accept && (opcode == OP_READ) && status.full;
		cmd.mem_rd = (state_q == ST_READ);
		cmd.load   = (state_q == ST_LOAD) && status.out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.rd) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_LOAD;
			ST_LOAD: begin
				// hold until the output register can take the pixel
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hdl/irot_dp.sv
// Datapath of the quarter-turn image rotator: configuration, counters, frame store
// and output register. Depends on irot_pkg; driven by irot_ctrl commands.
`timescale 1ns / 1ps

module irot_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic [irot_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [irot_pkg::SIZE_W-1:0] cfg_data,
	input  logic [irot_pkg::PIX_W-1:0]  pixel_in,
	input  irot_pkg::irot_cmd_t         cmd,
	output irot_pkg::irot_status_t      status,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [irot_pkg::OUT_W-1:0]  m_tdata,
	output logic                        m_tlast
);
	import irot_pkg::*;

	logic [SIZE_W-1:0]  image_rows_q;
	logic [SIZE_W-1:0]  image_cols_q;
	logic [1:0]         angle_code_q;
	logic               clockwise_q;

	logic [COORD_W-1:0] rows_m1, cols_m1, orow_m1, ocol_m1;
	logic [SIZE_W-1:0]  cols_eff;
	logic [1:0]         turns;

	logic [ADDR_W-1:0]  wr_idx_q;
	logic [COORD_W-1:0] wr_row_q, wr_col_q;
	logic               full_q;
	logic [COORD_W-1:0] rd_row_q, rd_col_q;
	logic               wr_last, rd_last, cfg_hit;

	logic [COORD_W-1:0] si, sj;
	logic [ADDR_W:0]    addr_full;

	logic [ADDR_W-1:0]  addr_s1;
	logic [COORD_W-1:0] row_s1, col_s1;
	logic               last_s1;
	logic [PIX_W-1:0]   pix_s2;
	logic               out_valid_q;

	logic [PIX_W-1:0]   frame_store [STORE_DEPTH];

	// Effective size minus one: zero acts as one, anything above the limit saturates
	always_comb begin
		if (image_rows_q == '0) begin
			rows_m1 = '0;
		end else if (image_rows_q > SIZE_W'(MAX_ROWS)) begin
			rows_m1 = COORD_W'(MAX_ROWS - 1);
		end else begin
			rows_m1 = COORD_W'(image_rows_q - 1'b1);
		end
		if (image_cols_q == '0) begin
			cols_m1 = '0;
		end else if (image_cols_q > SIZE_W'(MAX_COLS)) begin
			cols_m1 = COORD_W'(MAX_COLS - 1);
		end else begin
			cols_m1 = COORD_W'(image_cols_q - 1'b1);
		end
	end

	assign cols_eff = {1'b0, cols_m1} + 1'b1;

	always_comb begin
		case (angle_code_q)
			ANG_90:  turns = clockwise_q ? TURN_1 : TURN_3;
			ANG_270: turns = clockwise_q ? TURN_3 : TURN_1;
			ANG_180: turns = TURN_2;
			default: turns = TURN_0;
		endcase
	end

	assign orow_m1 = turns[0] ? cols_m1 : rows_m1;
	assign ocol_m1 = turns[0] ? rows_m1 : cols_m1;

	// Source coordinates of the current output pixel
	always_comb begin
		case (turns)
			TURN_1: begin
				si = rows_m1 - rd_col_q;
				sj = rd_row_q;
			end
			TURN_2: begin
				si = rows_m1 - rd_row_q;
				sj = cols_m1 - rd_col_q;
			end
			TURN_3: begin
				si = rd_col_q;
				sj = cols_m1 - rd_row_q;
			end
			default: begin
				si = rd_row_q;
				sj = rd_col_q;
			end
		endcase
	end

	assign addr_full = (17'(si) * 17'(cols_eff)) + 17'(sj);

	assign wr_last = (wr_row_q == rows_m1) && (wr_col_q == cols_m1);
	assign rd_last = (rd_row_q == orow_m1) && (rd_col_q == ocol_m1);
	assign cfg_hit = cfg_valid && (cfg_index == REG_IMAGE_ROWS || cfg_index == REG_IMAGE_COLS
		|| cfg_index == REG_ANGLE_CODE || cfg_index == REG_CLOCKWISE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q <= SIZE_W'(1);
			image_cols_q <= SIZE_W'(1);
			angle_code_q <= ANG_0;
			clockwise_q  <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_ROWS: image_rows_q <= cfg_data;
				REG_IMAGE_COLS: image_cols_q <= cfg_data;
				REG_ANGLE_CODE: angle_code_q <= cfg_data[1:0];
				REG_CLOCKWISE:  clockwise_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Write position, frame-complete flag and read position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			wr_row_q <= '0;
			wr_col_q <= '0;
			full_q   <= 1'b0;
			rd_row_q <= '0;
			rd_col_q <= '0;
		end else if (cfg_hit) begin
			wr_idx_q <= '0;
			wr_row_q <= '0;
			wr_col_q <= '0;
			full_q   <= 1'b0;
			rd_row_q <= '0;
			rd_col_q <= '0;
		end else if (cmd.wr) begin
			// a write into a complete frame starts a new one; the position is already zero
			if (full_q) begin
				rd_row_q <= '0;
				rd_col_q <= '0;
			end
			full_q <= wr_last;
			if (wr_last) begin
				wr_idx_q <= '0;
				wr_row_q <= '0;
				wr_col_q <= '0;
			end else begin
				wr_idx_q <= wr_idx_q + 1'b1;
				if (wr_col_q == cols_m1) begin
					wr_col_q <= '0;
					wr_row_q <= wr_row_q + 1'b1;
				end else begin
					wr_col_q <= wr_col_q + 1'b1;
				end
			end
		end else if (cmd.rd) begin
			if (rd_col_q == ocol_m1) begin
				rd_col_q <= '0;
				rd_row_q <= (rd_row_q == orow_m1) ? '0 : rd_row_q + 1'b1;
			end else begin
				rd_col_q <= rd_col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			addr_s1 <= addr_full[ADDR_W-1:0];
			row_s1  <= rd_row_q;
			col_s1  <= rd_col_q;
			last_s1 <= rd_last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			frame_store[wr_idx_q] <= pixel_in;
		end
		if (cmd.mem_rd) begin
			pix_s2 <= frame_store[addr_s1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_tdata <= {col_s1, row_s1, pix_s2};
			m_tlast <= last_s1;
		end
	end

	assign m_tvalid        = out_valid_q;
	assign status.full     = full_q;
	assign status.out_free = !out_valid_q || m_tready;

endmodule

### hdl/image_quarter_turn_rotator.sv
// Quarter-turn image rotator, top level: 8-bit grayscale frame of up to 256 x 256.
// Write beat: the pixel goes into the frame store when the beat is taken.
// Read beat: taken before the frame is complete, it gives no output; else the controller
// steps address, store read and output load, and takes no new beat until the load is done.
// Reset (arst_n low, asynchronous) restores the registers to 1 x 1, no turn,
// clockwise, and empties the frame; store contents are not cleared.
`timescale 1ns / 1ps

module image_quarter_turn_rotator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] pixel_in
	input  logic [0:0]                     s_tuser,   // [0] opcode
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [irot_pkg::OUT_W-1:0]     m_tdata,   // [7:0] pixel_out, [15:8] out_row,
	                                                  // [23:16] out_col
	output logic                           m_tlast,   // last_pixel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [irot_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [irot_pkg::SIZE_W-1:0]    cfg_data
);
	import irot_pkg::*;

	irot_cmd_t    cmd;
	irot_status_t status;

	assign cfg_ready = 1'b1;

	irot_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.opcode   (s_tuser[0]),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	irot_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel_in  (s_tdata[PIX_W-1:0]),
		.cmd       (cmd),
		.status    (status),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

### hdl/irot_checker.sv
// Port-level checks for the quarter-turn image rotator, bound to the top level.
// Depends on irot_pkg for widths.
`timescale 1ns / 1ps

module irot_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic [0:0]                  s_tuser,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [irot_pkg::OUT_W-1:0]  m_tdata,
	input logic                        m_tlast
);
	import irot_pkg::*;

	logic after_last_q;

	// Mark that the previous delivered beat closed the image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_last_q <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			after_last_q <= m_tlast;
		end
	end

	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output payload changed while stalled");

	a_write_single_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == OP_WRITE) |=> s_tready)
		else $error("write beat held up the input");

	a_restart_origin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && after_last_q |->
			m_tdata[PIX_W +: COORD_W] == '0 && m_tdata[PIX_W + COORD_W +: COORD_W] == '0)
		else $error("beat after last pixel does not start at row 0, column 0");

endmodule

bind image_quarter_turn_rotator irot_checker u_irot_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
